FILE: rtl/device_table_with_aging_top_assert.svh
// Assertion macros used by the checker of the device table.
`ifndef DEVICE_TABLE_WITH_AGING_TOP_ASSERT_SVH
`define DEVICE_TABLE_WITH_AGING_TOP_ASSERT_SVH

// A concurrent assertion on a clock with a synchronous reset as disable.
`define DTWA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// An implication whose consequence is checked in the cycle after its antecedent.
`define DTWA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   `DTWA_ASSERT(lbl, clk, rst, (ante) |=> (cons), msg)

`endif

FILE: rtl/dtwa_pkg.sv
// Package with the types, codes and helper functions of the device table.
package dtwa_pkg;

   localparam int unsigned DEPTH_DEFAULT = 64;
   localparam int unsigned CHANNEL_TOP   = 14;

   // Item kinds.
   typedef enum logic [1:0] {
      KIND_OBSERVE = 2'd0,
      KIND_TICK    = 2'd1,
      KIND_READ    = 2'd2,
      KIND_NONE    = 2'd3
   } kind_type;

   // Result status codes.
   typedef enum logic [2:0] {
      STAT_DONE      = 3'd0,
      STAT_INSERTED  = 3'd1,
      STAT_EVICTED   = 3'd2,
      STAT_IGNORED   = 3'd3,
      STAT_NOT_FOUND = 3'd4
   } status_type;

   // Configuration register indexes.
   localparam logic CSR_ACTIVE     = 1'b0;
   localparam logic CSR_IDLE_LIMIT = 1'b1;

   // Station roles.
   localparam logic [1:0] ROLE_UNKNOWN = 2'd0;
   localparam logic [1:0] ROLE_AP      = 2'd1;
   localparam logic [1:0] ROLE_STA     = 2'd2;
   localparam logic [1:0] ROLE_PEER    = 2'd3;

   // One device record as kept in the table memory.
   typedef struct packed {
      logic [47:0]        mac;
      logic [1:0]         role;
      logic [2:0]         flags;
      logic [31:0]        first;
      logic [31:0]        last;
      logic signed [7:0]  rmin;
      logic signed [7:0]  rmax;
      logic signed [7:0]  rlast;
      logic [13:0]        chans;
      logic [31:0]        count;
   } rec_type;

   // Flag bit for a role: access point, station and peer each own one bit.
   function automatic logic [2:0] role_bit(input logic [1:0] r);
      logic [2:0] b;
      case (r)
         ROLE_AP:   b = 3'b001;
         ROLE_STA:  b = 3'b010;
         ROLE_PEER: b = 3'b100;
         default:   b = 3'b000;
      endcase
      return b;
   endfunction

   // An unknown new role keeps the old one; two differing known roles make a peer.
   function automatic logic [1:0] role_merge(input logic [1:0] old_r, input logic [1:0] new_r);
      logic [1:0] m;
      if (new_r == ROLE_UNKNOWN) begin
         m = old_r;
      end else if (old_r == ROLE_UNKNOWN || old_r == new_r) begin
         m = new_r;
      end else begin
         m = ROLE_PEER;
      end
      return m;
   endfunction

   // Channel mask bit; channels outside 1 to 14 set nothing.
   function automatic logic [13:0] chan_bit(input logic [7:0] c);
      logic [13:0] m;
      m = '0;
      if (c >= 8'd1 && c <= 8'(CHANNEL_TOP)) begin
         m = 14'd1 << (c - 8'd1);
      end
      return m;
   endfunction

endpackage

FILE: rtl/dtwa_req_if.sv
// Request channel interface of the device table.
interface dtwa_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        kind;
   logic [47:0]       station_mac;
   logic [1:0]        station_role;
   logic signed [7:0] signal_dbm;
   logic [7:0]        radio_channel;
   logic [31:0]       time_ms;
   logic [5:0]        entry_number;

   modport source (output valid, kind, station_mac, station_role, signal_dbm,
                   radio_channel, time_ms, entry_number, input ready);
   modport sink (input valid, kind, station_mac, station_role, signal_dbm,
                 radio_channel, time_ms, entry_number, output ready);
endinterface

FILE: rtl/dtwa_rsp_if.sv
// Result channel interface of the device table.
interface dtwa_rsp_if;
   logic              valid;
   logic              ready;
   logic [2:0]        status;
   logic [47:0]       device_mac;
   logic [1:0]        merged_role;
   logic [2:0]        role_seen_flags;
   logic [31:0]       first_seen;
   logic [31:0]       last_seen;
   logic signed [7:0] signal_min;
   logic signed [7:0] signal_max;
   logic signed [7:0] signal_last;
   logic [13:0]       channel_mask;
   logic [31:0]       sighting_count;
   logic [6:0]        occupied_count;

   modport source (output valid, status, device_mac, merged_role, role_seen_flags,
                   first_seen, last_seen, signal_min, signal_max, signal_last,
                   channel_mask, sighting_count, occupied_count, input ready);
   modport sink (input valid, status, device_mac, merged_role, role_seen_flags,
                 first_seen, last_seen, signal_min, signal_max, signal_last,
                 channel_mask, sighting_count, occupied_count, output ready);
endinterface

FILE: rtl/device_table_with_aging_top.sv
// Top level of the device table with aging.
// Every item makes one pass over the active slots and then a write-back
// step, after which the sequencer returns to idle and takes the next item.
// The pass is set by the single read port of the record memory, which
// delivers one slot per cycle; aging, address match, free-slot and
// oldest-slot search and the ordinal count for reads all ride on that same
// pass. The result sits in an output register, so a stalled result holds
// only the next item's write-back. Configuration is to be written through
// the csr port while no item is in flight; the block does not enforce it.
module device_table_with_aging_top
   import dtwa_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   dtwa_req_if.sink    req_ch,
   dtwa_rsp_if.source  rsp_ch,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int unsigned AddrW = $clog2(TABLE_DEPTH);

   logic [6:0]       active_ff;
   logic [31:0]      limit_ff;
   logic [AddrW-1:0] rd_addr;
   rec_type          rd_data;
   logic             wr_en;
   logic [AddrW-1:0] wr_addr;
   rec_type          wr_data;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 7'd64;
         limit_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ACTIVE:     active_ff <= csr_wdata[6:0];
            CSR_IDLE_LIMIT: limit_ff  <= csr_wdata;
            default:        limit_ff  <= limit_ff;
         endcase
      end
   end

   dtwa_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req            (req_ch),
      .rsp            (rsp_ch),
      .active_entries (active_ff),
      .idle_limit_ms  (limit_ff),
      .mem_rd_addr    (rd_addr),
      .mem_rd_data    (rd_data),
      .mem_wr_en      (wr_en),
      .mem_wr_addr    (wr_addr),
      .mem_wr_data    (wr_data)
   );

   dtwa_store #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_store (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

endmodule

FILE: rtl/dtwa_store.sv
// Record memory of the device table: one write port, one registered read port.
module dtwa_store
   import dtwa_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = DEPTH_DEFAULT,
   localparam int unsigned AddrW = $clog2(TABLE_DEPTH)
) (
   input  logic             clock,
   input  logic [AddrW-1:0] rd_addr,
   output rec_type          rd_data,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  rec_type          wr_data
);

   rec_type mem [TABLE_DEPTH];
   rec_type rd_data_ff;

   // Synchronous write.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read data is registered and arrives in the cycle after the address.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/dtwa_ctrl.sv
// Sequencer of the device table: one scan over the slots, then the write back.
module dtwa_ctrl
   import dtwa_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = DEPTH_DEFAULT,
   localparam int unsigned AddrW = $clog2(TABLE_DEPTH)
) (
   input  logic             clock,
   input  logic             reset,
   dtwa_req_if.sink         req,
   dtwa_rsp_if.source       rsp,
   input  logic [6:0]       active_entries,
   input  logic [31:0]      idle_limit_ms,
   output logic [AddrW-1:0] mem_rd_addr,
   input  rec_type          mem_rd_data,
   output logic             mem_wr_en,
   output logic [AddrW-1:0] mem_wr_addr,
   output rec_type          mem_wr_data
);

   localparam int unsigned CntW = AddrW + 1;
   localparam int unsigned ExtW = (CntW > 7) ? CntW : 7;

   typedef enum logic [2:0] {
      SEQ_IDLE  = 3'b001,
      SEQ_SCAN  = 3'b010,
      SEQ_WRITE = 3'b100
   } seq_state_type;

   seq_state_type state_ff, state_in;

   // Item fields held for the whole item.
   logic [1:0]        kind_ff;
   logic [47:0]       mac_ff;
   logic [1:0]        role_ff;
   logic signed [7:0] rssi_ff;
   logic [7:0]        chan_ff;
   logic [31:0]       now_ff;
   logic [5:0]        want_ff;
   logic [CntW-1:0]   live_ff;

   // Scan pipeline and search results.
   logic [CntW-1:0]    iss_ff;
   logic               rd_vld_ff;
   logic [AddrW-1:0]   rd_idx_ff;
   logic [TABLE_DEPTH-1:0] used_ff, used_in;
   logic               found_ff;
   logic [AddrW-1:0]   match_idx_ff;
   logic               free_found_ff;
   logic [AddrW-1:0]   free_idx_ff;
   logic [AddrW-1:0]   old_idx_ff;
   logic [31:0]        min_last_ff;
   logic               hit_ff;
   logic [6:0]         seen_ff;
   logic [CntW-1:0]    occ_ff;
   rec_type            cap_ff;

   // Result register.
   logic               rsp_valid_ff;
   logic [2:0]         rsp_status_ff;
   rec_type            rsp_rec_ff;
   logic [6:0]         rsp_occ_ff;

   logic [ExtW-1:0]    act_ext;
   logic [CntW-1:0]    live;
   logic               accept;
   logic               issuing;
   logic               age_on;
   logic               u_old;
   logic               expire;
   logic               u_new;
   logic               out_free;
   logic               finish;
   logic               do_obs;
   logic [AddrW-1:0]   wr_idx;
   status_type         status;
   rec_type            new_rec;
   rec_type            out_rec;
   logic [CntW-1:0]    occ_out;

   // Effective table size: zero acts as one, oversize as the built depth.
   always_comb begin
      act_ext = ExtW'(active_entries);
      if (act_ext == '0) begin
         live = CntW'(1);
      end else if (act_ext > ExtW'(TABLE_DEPTH)) begin
         live = CntW'(TABLE_DEPTH);
      end else begin
         live = CntW'(act_ext);
      end
   end

   assign req.ready = (state_ff == SEQ_IDLE);
   assign accept    = req.valid && req.ready;
   assign issuing   = (state_ff == SEQ_SCAN) && (iss_ff < live_ff);
   assign mem_rd_addr = iss_ff[AddrW-1:0];

   // Aging of the slot whose record is on the read port.
   always_comb begin
      age_on = (kind_ff == KIND_OBSERVE) || (kind_ff == KIND_TICK);
      u_old  = used_ff[rd_idx_ff];
      expire = age_on && u_old && (idle_limit_ms != '0) &&
               (now_ff >= mem_rd_data.last) &&
               ((now_ff - mem_rd_data.last) >= idle_limit_ms);
      u_new  = u_old && !expire;
   end

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign finish   = (state_ff == SEQ_WRITE) && out_free;
   assign do_obs   = (kind_ff == KIND_OBSERVE) && (mac_ff != '0);

   // Merged or freshly allocated record for an observation.
   always_comb begin
      new_rec = '0;
      new_rec.mac   = mac_ff;
      new_rec.rlast = rssi_ff;
      if (found_ff) begin
         new_rec.role  = role_merge(cap_ff.role, role_ff);
         new_rec.flags = cap_ff.flags | role_bit(role_ff);
         new_rec.first = (now_ff < cap_ff.first) ? now_ff : cap_ff.first;
         new_rec.last  = (now_ff > cap_ff.last) ? now_ff : cap_ff.last;
         new_rec.rmin  = (rssi_ff < cap_ff.rmin) ? rssi_ff : cap_ff.rmin;
         new_rec.rmax  = (rssi_ff > cap_ff.rmax) ? rssi_ff : cap_ff.rmax;
         new_rec.chans = cap_ff.chans | chan_bit(chan_ff);
         new_rec.count = cap_ff.count + 32'd1;
      end else begin
         new_rec.role  = role_ff;
         new_rec.flags = role_bit(role_ff);
         new_rec.first = now_ff;
         new_rec.last  = now_ff;
         new_rec.rmin  = rssi_ff;
         new_rec.rmax  = rssi_ff;
         new_rec.chans = chan_bit(chan_ff);
         new_rec.count = 32'd1;
      end
   end

   // Slot choice and result of the item.
   always_comb begin
      if (found_ff) begin
         wr_idx = match_idx_ff;
      end else if (free_found_ff) begin
         wr_idx = free_idx_ff;
      end else begin
         wr_idx = old_idx_ff;
      end
      status  = STAT_DONE;
      out_rec = '0;
      unique case (kind_ff)
         KIND_OBSERVE: begin
            if (mac_ff == '0) begin
               status = STAT_IGNORED;
            end else begin
               out_rec = new_rec;
               if (found_ff) begin
                  status = STAT_DONE;
               end else if (free_found_ff) begin
                  status = STAT_INSERTED;
               end else begin
                  status = STAT_EVICTED;
               end
            end
         end
         KIND_READ: begin
            if (hit_ff) begin
               out_rec = cap_ff;
            end else begin
               status = STAT_NOT_FOUND;
            end
         end
         KIND_TICK, KIND_NONE: begin
            status = STAT_DONE;
         end
         default: begin
            status = STAT_DONE;
         end
      endcase
      occ_out = occ_ff + ((status == STAT_INSERTED) ? CntW'(1) : CntW'(0));
   end

   assign mem_wr_en   = finish && do_obs;
   assign mem_wr_addr = wr_idx;
   assign mem_wr_data = new_rec;

   // Used bits: cleared by aging during the scan, set on allocation.
   always_comb begin
      used_in = used_ff;
      if (rd_vld_ff) begin
         used_in[rd_idx_ff] = u_new;
      end
      if (finish && do_obs) begin
         used_in[wr_idx] = 1'b1;
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (accept) begin
               state_in = SEQ_SCAN;
            end
         end
         SEQ_SCAN: begin
            if (!issuing && !rd_vld_ff) begin
               state_in = SEQ_WRITE;
            end
         end
         SEQ_WRITE: begin
            if (out_free) begin
               state_in = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         used_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         used_ff   <= used_in;
         rd_vld_ff <= issuing;
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Item capture and scan bookkeeping.
   always_ff @(posedge clock) begin
      rd_idx_ff <= iss_ff[AddrW-1:0];
      if (accept) begin
         kind_ff       <= req.kind;
         mac_ff        <= req.station_mac;
         role_ff       <= req.station_role;
         rssi_ff       <= req.signal_dbm;
         chan_ff       <= req.radio_channel;
         now_ff        <= req.time_ms;
         want_ff       <= req.entry_number;
         live_ff       <= live;
         iss_ff        <= '0;
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         hit_ff        <= 1'b0;
         seen_ff       <= '0;
         occ_ff        <= '0;
         old_idx_ff    <= '0;
      end else begin
         if (issuing) begin
            iss_ff <= iss_ff + CntW'(1);
         end
         if (rd_vld_ff) begin
            occ_ff <= occ_ff + (u_new ? CntW'(1) : CntW'(0));
            // First slot holding the address.
            if (kind_ff == KIND_OBSERVE && !found_ff && u_new &&
                mem_rd_data.mac == mac_ff) begin
               found_ff     <= 1'b1;
               match_idx_ff <= rd_idx_ff;
               cap_ff       <= mem_rd_data;
            end
            // Lowest free slot.
            if (!free_found_ff && !u_new) begin
               free_found_ff <= 1'b1;
               free_idx_ff   <= rd_idx_ff;
            end
            // Least recently seen slot, lowest on ties.
            if (rd_idx_ff == '0 || mem_rd_data.last < min_last_ff) begin
               min_last_ff <= mem_rd_data.last;
               old_idx_ff  <= rd_idx_ff;
            end
            // Ordinal search for a read.
            if (kind_ff == KIND_READ && !hit_ff && u_new) begin
               if (seen_ff == 7'(want_ff)) begin
                  hit_ff <= 1'b1;
                  cap_ff <= mem_rd_data;
               end else begin
                  seen_ff <= seen_ff + 7'd1;
               end
            end
         end
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_status_ff <= status;
         rsp_rec_ff    <= out_rec;
         rsp_occ_ff    <= 7'(occ_out);
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.status          = rsp_status_ff;
   assign rsp.device_mac      = rsp_rec_ff.mac;
   assign rsp.merged_role     = rsp_rec_ff.role;
   assign rsp.role_seen_flags = rsp_rec_ff.flags;
   assign rsp.first_seen      = rsp_rec_ff.first;
   assign rsp.last_seen       = rsp_rec_ff.last;
   assign rsp.signal_min      = rsp_rec_ff.rmin;
   assign rsp.signal_max      = rsp_rec_ff.rmax;
   assign rsp.signal_last     = rsp_rec_ff.rlast;
   assign rsp.channel_mask    = rsp_rec_ff.chans;
   assign rsp.sighting_count  = rsp_rec_ff.count;
   assign rsp.occupied_count  = rsp_occ_ff;

endmodule

FILE: rtl/dtwa_checker.sv
// Port-level checker of the device table and its bind to the top level.
`include "device_table_with_aging_top_assert.svh"

module dtwa_checker
   import dtwa_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [47:0] rsp_mac,
   input logic [31:0] rsp_count
);

   // A stalled result keeps its status.
   `DTWA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status), "stalled result changed")

   // The table works on one item at a time.
   `DTWA_ASSERT_NEXT(a_one_item, clock, reset, req_valid && req_ready, !req_ready, "item taken while busy")

   // Status codes stay within the defined set.
   `DTWA_ASSERT(a_status_range, clock, reset, rsp_valid |-> (rsp_status <= STAT_NOT_FOUND), "bad status code")

   // A fresh entry carries its address and exactly one sighting.
   `DTWA_ASSERT(a_insert_rec, clock, reset, rsp_valid && ((rsp_status == STAT_INSERTED) || (rsp_status == STAT_EVICTED)) |-> (rsp_mac != '0) && (rsp_count == 32'd1), "bad inserted record")

   // An ignored or missed item returns an empty record.
   `DTWA_ASSERT(a_empty_rec, clock, reset, rsp_valid && ((rsp_status == STAT_IGNORED) || (rsp_status == STAT_NOT_FOUND)) |-> (rsp_mac == '0) && (rsp_count == '0), "record not empty")

endmodule

bind device_table_with_aging_top dtwa_checker u_dtwa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_status (rsp_ch.status),
   .rsp_mac    (rsp_ch.device_mac),
   .rsp_count  (rsp_ch.sighting_count)
);
